[rtl/pad_edge_and_autorepeat_assert.svh]
// ----------------------------------------------------------------------------
// Pad edge and autorepeat assertion macros
// Shorthand for clocked assertions with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef PAD_EDGE_AND_AUTOREPEAT_ASSERT_SVH
`define PAD_EDGE_AND_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PAE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pad_edge_and_autorepeat: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define PAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pad_edge_and_autorepeat: next-cycle check failed");

`endif

[rtl/pae_pkg.sv]
// ----------------------------------------------------------------------------
// Pad edge and autorepeat package
// Beat types, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package pae_pkg;

    // Lowest bit of the eight stick direction bits in the button word
    localparam int DIR_BIT_BASE = 20;

    // Direction bit offsets from the base
    localparam int DIR_LEFT_UP     = 0;
    localparam int DIR_LEFT_RIGHT  = 1;
    localparam int DIR_LEFT_DOWN   = 2;
    localparam int DIR_LEFT_LEFT   = 3;
    localparam int DIR_RIGHT_UP    = 4;
    localparam int DIR_RIGHT_RIGHT = 5;
    localparam int DIR_RIGHT_DOWN  = 6;
    localparam int DIR_RIGHT_LEFT  = 7;

    // Configuration register indexes
    localparam logic [2:0] CFG_AXIS_CENTER    = 3'd0;
    localparam logic [2:0] CFG_AXIS_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_REPEAT_DELAY   = 3'd2;
    localparam logic [2:0] CFG_REPEAT_RELOAD  = 3'd3;
    localparam logic [2:0] CFG_HELD_DELAY     = 3'd4;

    // Configuration reset values
    localparam logic [7:0] RST_AXIS_CENTER    = 8'd128;
    localparam logic [7:0] RST_AXIS_THRESHOLD = 8'd64;
    localparam logic [3:0] RST_REPEAT_DELAY   = 4'd10;
    localparam logic [3:0] RST_REPEAT_RELOAD  = 4'd6;
    localparam logic [3:0] RST_HELD_DELAY     = 4'd10;

    typedef struct packed {
        logic [7:0] axis_center;
        logic [7:0] axis_threshold;
        logic [3:0] repeat_delay;
        logic [3:0] repeat_reload;
        logic [3:0] held_delay;
    } pae_cfg_t;

    typedef struct packed {
        logic [31:0] raw_buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } pae_in_t;

    typedef struct packed {
        logic [31:0] current_mask;
        logic [31:0] pressed_mask;
        logic [31:0] released_mask;
        logic [31:0] repeat_mask;
        logic [31:0] held_mask;
    } pae_out_t;

endpackage

[rtl/pae_dirmerge.sv]
// ----------------------------------------------------------------------------
// Stick direction merge
// Compares the four stick axes against center -/+ threshold and ORs the
// resulting direction bits into the raw button word.
// ----------------------------------------------------------------------------
module pae_dirmerge (
    input  pae_pkg::pae_in_t  beat,
    input  pae_pkg::pae_cfg_t cfg,
    output logic [31:0]       cur_word
);
    import pae_pkg::*;

    logic signed [9:0] lo_bound;
    logic        [8:0] hi_bound;
    logic [3:0]        below;
    logic [3:0]        above;
    logic [7:0]        axis_val [4];

    // Lower bound may go negative; upper bound may pass 255
    assign lo_bound = $signed({2'b00, cfg.axis_center}) - $signed({2'b00, cfg.axis_threshold});
    assign hi_bound = {1'b0, cfg.axis_center} + {1'b0, cfg.axis_threshold};

    assign axis_val[0] = beat.left_y;
    assign axis_val[1] = beat.left_x;
    assign axis_val[2] = beat.right_y;
    assign axis_val[3] = beat.right_x;

    // Compare each axis; below wins over above
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            below[i] = $signed({2'b00, axis_val[i]}) < lo_bound;
            above[i] = !below[i] && ({1'b0, axis_val[i]} > hi_bound);
        end
    end

    // Merge direction bits into the button word
    always_comb
    begin
        cur_word = beat.raw_buttons;
        cur_word[DIR_BIT_BASE + DIR_LEFT_UP]     = cur_word[DIR_BIT_BASE + DIR_LEFT_UP]     | below[0];
        cur_word[DIR_BIT_BASE + DIR_LEFT_DOWN]   = cur_word[DIR_BIT_BASE + DIR_LEFT_DOWN]   | above[0];
        cur_word[DIR_BIT_BASE + DIR_LEFT_LEFT]   = cur_word[DIR_BIT_BASE + DIR_LEFT_LEFT]   | below[1];
        cur_word[DIR_BIT_BASE + DIR_LEFT_RIGHT]  = cur_word[DIR_BIT_BASE + DIR_LEFT_RIGHT]  | above[1];
        cur_word[DIR_BIT_BASE + DIR_RIGHT_UP]    = cur_word[DIR_BIT_BASE + DIR_RIGHT_UP]    | below[2];
        cur_word[DIR_BIT_BASE + DIR_RIGHT_DOWN]  = cur_word[DIR_BIT_BASE + DIR_RIGHT_DOWN]  | above[2];
        cur_word[DIR_BIT_BASE + DIR_RIGHT_LEFT]  = cur_word[DIR_BIT_BASE + DIR_RIGHT_LEFT]  | below[3];
        cur_word[DIR_BIT_BASE + DIR_RIGHT_RIGHT] = cur_word[DIR_BIT_BASE + DIR_RIGHT_RIGHT] | above[3];
    end

endmodule

[rtl/pae_track.sv]
// ----------------------------------------------------------------------------
// Edge and repeat tracker
// Keeps the previous word and the repeat and held counters, and forms the
// five output masks for the word being stepped.
// ----------------------------------------------------------------------------
module pae_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [31:0]       cur_word,
    input  pae_pkg::pae_cfg_t cfg,
    output pae_pkg::pae_out_t result
);
    import pae_pkg::*;

    logic [31:0] prev_word_reg;
    logic [31:0] prev_word_next;
    logic [3:0]  repeat_cnt_reg;
    logic [3:0]  repeat_cnt_next;
    logic [3:0]  held_cnt_reg;
    logic [3:0]  held_cnt_next;
    logic [4:0]  repeat_inc;
    logic [4:0]  held_inc;
    logic        unchanged;
    logic        repeat_fire;
    logic        held_fire;
    logic [31:0] pressed;

    assign unchanged   = (cur_word == prev_word_reg);
    assign repeat_inc  = {1'b0, repeat_cnt_reg} + 5'd1;
    assign held_inc    = {1'b0, held_cnt_reg} + 5'd1;
    assign repeat_fire = unchanged && (repeat_inc >= {1'b0, cfg.repeat_delay});
    assign held_fire   = unchanged && (held_inc >= {1'b0, cfg.held_delay});
    assign pressed     = cur_word & ~prev_word_reg;

    // Form the output masks
    always_comb
    begin
        result.current_mask  = cur_word;
        result.pressed_mask  = pressed;
        result.released_mask = ~cur_word & prev_word_reg;
        result.repeat_mask   = repeat_fire ? cur_word : pressed;
        result.held_mask     = held_fire ? cur_word : pressed;
    end

    // On a step, advance counters on an unchanged word (reloading them when they fire), clear them on a change
    always_comb
    begin
        prev_word_next  = prev_word_reg;
        repeat_cnt_next = repeat_cnt_reg;
        held_cnt_next   = held_cnt_reg;
        if (step)
        begin
            if (unchanged)
            begin
                repeat_cnt_next = repeat_fire ? cfg.repeat_reload : repeat_inc[3:0];
                held_cnt_next   = held_fire ? cfg.held_delay : held_inc[3:0];
            end
            else
            begin
                prev_word_next  = cur_word;
                repeat_cnt_next = 4'd0;
                held_cnt_next   = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg  <= '0;
            repeat_cnt_reg <= '0;
            held_cnt_reg   <= '0;
        end
        else
        begin
            prev_word_reg  <= prev_word_next;
            repeat_cnt_reg <= repeat_cnt_next;
            held_cnt_reg   <= held_cnt_next;
        end
    end

endmodule

[rtl/pad_edge_and_autorepeat.sv]
// ----------------------------------------------------------------------------
// Pad edge and autorepeat
// Controller poll edge detector with stick direction merge and auto-repeat.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is held in the input register, stepped through
// the tracker once the output slot is free, and registered in the result register.
// Throughput: one poll per cycle unless the output stalls; the state update is
// a step between the input register and the result register.
// Reset: configuration returns to its defaults, previous word and both
// counters clear, and both pipeline registers empty.
module pad_edge_and_autorepeat (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pae_pkg::pae_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pae_pkg::pae_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import pae_pkg::*;

    `include "pad_edge_and_autorepeat_assert.svh"

    pae_cfg_t    cfg_reg;
    pae_cfg_t    cfg_next;
    logic        in_valid_reg;
    logic        in_valid_next;
    pae_in_t     in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    pae_out_t    out_data_reg;
    logic        out_adv;
    logic        step;
    logic [31:0] cur_word;
    pae_out_t    result;
    logic        masks_cover;
    logic        masks_plain;
    logic        word_moved;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_AXIS_CENTER:    cfg_next.axis_center    = cfg_data;
                CFG_AXIS_THRESHOLD: cfg_next.axis_threshold = cfg_data;
                CFG_REPEAT_DELAY:   cfg_next.repeat_delay   = cfg_data[3:0];
                CFG_REPEAT_RELOAD:  cfg_next.repeat_reload  = cfg_data[3:0];
                CFG_HELD_DELAY:     cfg_next.held_delay     = cfg_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.axis_center    <= RST_AXIS_CENTER;
            cfg_reg.axis_threshold <= RST_AXIS_THRESHOLD;
            cfg_reg.repeat_delay   <= RST_REPEAT_DELAY;
            cfg_reg.repeat_reload  <= RST_REPEAT_RELOAD;
            cfg_reg.held_delay     <= RST_HELD_DELAY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline handshake: output slot frees when empty or taken
    assign out_adv        = !out_valid_reg || out_ready;
    assign step           = in_valid_reg && out_adv;
    assign in_ready       = !in_valid_reg || out_adv;
    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !out_adv);
    assign out_valid_next = step || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input beat and result beat
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    pae_dirmerge u_dirmerge (
        .beat     (in_data_reg),
        .cfg      (cfg_reg),
        .cur_word (cur_word)
    );

    pae_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_word (cur_word),
        .cfg      (cfg_reg),
        .result   (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Mask relations on the result beat
    assign masks_cover = ((out_data_reg.pressed_mask & ~out_data_reg.repeat_mask) == 32'd0)
                      && ((out_data_reg.pressed_mask & ~out_data_reg.held_mask) == 32'd0);
    assign masks_plain = (out_data_reg.repeat_mask == out_data_reg.pressed_mask)
                      && (out_data_reg.held_mask == out_data_reg.pressed_mask);
    assign word_moved  = (out_data_reg.pressed_mask | out_data_reg.released_mask) != 32'd0;

    // A stalled input beat holds in its register
    `PAE_ASSERT_NEXT(a_in_hold, in_valid_reg && !out_adv, in_valid_reg && $stable(in_data_reg))

    // A stepped beat shows up as a result beat
    `PAE_ASSERT_NEXT(a_step_out, step, out_valid_reg)

    // Repeat and held masks always cover the pressed edges
    `PAE_ASSERT_NOW(a_cover, out_valid_reg, masks_cover)

    // On a changed word no repeat or held firing is mixed in
    `PAE_ASSERT_NOW(a_change, out_valid_reg && word_moved, masks_plain)

endmodule
